FILE: rtl/cma_pkg.sv
// Shared types and constants for the constant-modulus adaptive equaliser.
`timescale 1ns / 1ps
`default_nettype none

package cma_pkg;

  typedef struct packed {
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
  } in_t;

  typedef struct packed {
    logic signed [23:0] eq_re;
    logic signed [23:0] eq_im;
    logic [31:0]        err_power;
    logic               diverged;
  } out_t;

  typedef struct packed {
    logic [15:0] modulus_sq;
    logic [23:0] mu;
    logic [15:0] leak_factor;
    logic [31:0] grad_limit;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [31:0]        limit;
  } clip_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } clip_rsp_t;

  localparam int ADDR_W = 4;

  localparam logic [1:0] REG_MODULUS_SQ  = 2'd0;
  localparam logic [1:0] REG_MU          = 2'd1;
  localparam logic [1:0] REG_LEAK_FACTOR = 2'd2;
  localparam logic [1:0] REG_GRAD_LIMIT  = 2'd3;

  localparam logic [15:0] RST_MODULUS_SQ  = 16'd4096;
  localparam logic [23:0] RST_MU          = 24'd16777;
  localparam logic [15:0] RST_LEAK_FACTOR = 16'd0;
  localparam logic [31:0] RST_GRAD_LIMIT  = 32'd65536000;

  localparam logic signed [23:0] ONE_Q16 = 24'sd65536;
  localparam logic [31:0]        W_CLIP  = 32'd6553600;

endpackage

`default_nettype wire

FILE: rtl/cma_regs.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module cma_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [cma_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output cma_pkg::cfg_t                   cfg_o
);

  cma_pkg::cfg_t cfg_q;
  logic          wr_en;
  logic [1:0]    idx;

  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[3:2];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.modulus_sq  <= cma_pkg::RST_MODULUS_SQ;
      cfg_q.mu          <= cma_pkg::RST_MU;
      cfg_q.leak_factor <= cma_pkg::RST_LEAK_FACTOR;
      cfg_q.grad_limit  <= cma_pkg::RST_GRAD_LIMIT;
    end else if (wr_en) begin
      case (idx)
        cma_pkg::REG_MODULUS_SQ:  cfg_q.modulus_sq  <= pwdata[15:0];
        cma_pkg::REG_MU:          cfg_q.mu          <= pwdata[23:0];
        cma_pkg::REG_LEAK_FACTOR: cfg_q.leak_factor <= pwdata[15:0];
        cma_pkg::REG_GRAD_LIMIT:  cfg_q.grad_limit  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      cma_pkg::REG_MODULUS_SQ:  prdata = {16'd0, cfg_q.modulus_sq};
      cma_pkg::REG_MU:          prdata = {8'd0, cfg_q.mu};
      cma_pkg::REG_LEAK_FACTOR: prdata = {16'd0, cfg_q.leak_factor};
      cma_pkg::REG_GRAD_LIMIT:  prdata = cfg_q.grad_limit;
      default:                  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/cma_clip.sv
// Complex magnitude clip unit with an iterative square root and divider.
`timescale 1ns / 1ps
`default_nettype none

module cma_clip (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cma_pkg::clip_req_t req_i,
  output cma_pkg::clip_rsp_t      rsp_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQA, S_SQB, S_SQL, S_ROOT, S_MULA, S_DIVA, S_MULB, S_DIVB
  } state_e;

  state_e             state_q;
  logic [30:0]        ua_q, ub_q;
  logic               neg_a_q, neg_b_q;
  logic [31:0]        lim_q;
  logic [63:0]        acc_q, root_q, bit_q;
  logic [4:0]         cnt_q;
  logic [31:0]        m_q, rem_q, quo_q;
  logic signed [31:0] res_a_q, res_b_q;
  logic               done_q;

  logic [31:0] mul_x, mul_y;
  logic [63:0] prod, rb, root_d;
  logic        root_ge, div_ge;
  logic [32:0] rs;
  logic [31:0] rem_d, quo_d;

  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (state_q)
      S_SQA: begin
        mul_x = {1'b0, ua_q};
        mul_y = {1'b0, ua_q};
      end
      S_SQB: begin
        mul_x = {1'b0, ub_q};
        mul_y = {1'b0, ub_q};
      end
      S_SQL: begin
        mul_x = lim_q;
        mul_y = lim_q;
      end
      S_MULA: begin
        mul_x = {1'b0, ua_q};
        mul_y = lim_q;
      end
      S_MULB: begin
        mul_x = {1'b0, ub_q};
        mul_y = lim_q;
      end
      default: ;
    endcase
    prod    = 64'(mul_x) * 64'(mul_y);
    rb      = root_q + bit_q;
    root_ge = acc_q >= rb;
    root_d  = root_ge ? (root_q >> 1) + bit_q : root_q >> 1;
    rs      = {rem_q, acc_q[63]};
    div_ge  = rs >= {1'b0, m_q};
    rem_d   = div_ge ? 32'(rs - {1'b0, m_q}) : rs[31:0];
    quo_d   = {quo_q[30:0], div_ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ua_q    <= '0;
      ub_q    <= '0;
      neg_a_q <= 1'b0;
      neg_b_q <= 1'b0;
      lim_q   <= '0;
      acc_q   <= '0;
      root_q  <= '0;
      bit_q   <= '0;
      cnt_q   <= '0;
      m_q     <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      res_a_q <= '0;
      res_b_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_i.start) begin
            ua_q    <= req_i.a[31] ? 31'(-req_i.a) : req_i.a[30:0];
            ub_q    <= req_i.b[31] ? 31'(-req_i.b) : req_i.b[30:0];
            neg_a_q <= req_i.a[31];
            neg_b_q <= req_i.b[31];
            lim_q   <= req_i.limit;
            res_a_q <= req_i.a;
            res_b_q <= req_i.b;
            state_q <= S_SQA;
          end
        end
        S_SQA: begin
          acc_q   <= prod;
          state_q <= S_SQB;
        end
        S_SQB: begin
          acc_q   <= acc_q + prod;
          state_q <= S_SQL;
        end
        S_SQL: begin
          if (acc_q <= prod) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            root_q  <= '0;
            bit_q   <= 64'h4000_0000_0000_0000;
            cnt_q   <= '0;
            state_q <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (root_ge) begin
            acc_q <= acc_q - rb;
          end
          root_q <= root_d;
          bit_q  <= bit_q >> 2;
          cnt_q  <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            m_q     <= root_d[31:0];
            state_q <= S_MULA;
          end
        end
        S_MULA, S_MULB: begin
          rem_q   <= prod[63:32];
          acc_q   <= {prod[31:0], 32'd0};
          quo_q   <= '0;
          cnt_q   <= '0;
          state_q <= (state_q == S_MULA) ? S_DIVA : S_DIVB;
        end
        S_DIVA, S_DIVB: begin
          rem_q <= rem_d;
          quo_q <= quo_d;
          acc_q <= acc_q << 1;
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            if (state_q == S_DIVA) begin
              res_a_q <= neg_a_q ? (32'd0 - quo_d) : quo_d;
              state_q <= S_MULB;
            end else begin
              res_b_q <= neg_b_q ? (32'd0 - quo_d) : quo_d;
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o = '{done: done_q, a: res_a_q, b: res_b_q};

endmodule

`default_nettype wire

FILE: rtl/cma_core.sv
// Tap memories, filter and adaptation sequencer of the equaliser.
`timescale 1ns / 1ps
`default_nettype none

module cma_core #(
  parameter int TAPS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cma_pkg::cfg_t      cfg_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire cma_pkg::in_t       in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output cma_pkg::out_t           out_data_o,
  output cma_pkg::clip_req_t      clip_req_o,
  input  wire cma_pkg::clip_rsp_t clip_rsp_i
);

  localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int SW = 41 + AW;
  localparam int YW = SW - 14;
  localparam int PW = 58;
  localparam logic [AW-1:0] LAST   = AW'(TAPS - 1);
  localparam logic [AW-1:0] CENTER = AW'(TAPS / 2);
  localparam logic [AW:0]   DEPTH  = (AW + 1)'(TAPS);

  typedef enum logic [4:0] {
    S_IDLE, S_FRD, S_FMUL, S_FACC, S_Y, S_E1, S_E2, S_E3, S_E4, S_E5,
    S_P1, S_P2, S_P3, S_URD, S_G1, S_G2, S_G3, S_G4, S_G5, S_GC,
    S_N1, S_N2, S_N3, S_N4, S_N5, S_WC, S_FIN
  } state_e;

  function automatic logic signed [31:0] sat_part(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sd2147483647;
    end else if (v < -64'sd2147483647) begin
      return -32'sd2147483647;
    end else begin
      return v[31:0];
    end
  endfunction

  logic [31:0] dmem [TAPS];
  logic [47:0] wmem [TAPS];
  logic [31:0] drd_q;
  logic [47:0] wrd_q;

  state_e             state_q;
  logic [AW-1:0]      head_q, k_q, head_nxt, daddr;
  logic [TAPS-1:0]    dvalid_q, wvalid_q;
  logic               dval_q, wval_q;
  logic signed [15:0] x_re, x_im, x_re_q, x_im_q;
  logic signed [23:0] w_re, w_im, w_re_q, w_im_q;
  logic signed [39:0] m_rr_q, m_ii_q, m_ri_q, m_ir_q;
  logic signed [SW-1:0] sr_q, si_q, sr_rnd, si_rnd;
  logic signed [YW-1:0] yr_full, yi_full;
  logic               ovf_r, ovf_i;
  logic signed [23:0] yr_sat, yi_sat, yr_q, yi_q, ysel;
  logic signed [47:0] ysq;
  logic [47:0]        mag_q;
  logic [47:0]        mag_rnd;
  logic signed [28:0] d_q;
  logic signed [52:0] yd, yd_rnd;
  logic signed [40:0] er_q, ei_q, esel;
  logic [40:0]        ear, eai;
  logic [23:0]        psel_e;
  logic [47:0]        psq;
  logic [48:0]        pwacc_q;
  logic               pwsat_q;
  logic signed [15:0] gx;
  logic signed [PW-1:0] pa_q, pb_q, gprod, sgprod;
  logic signed [41:0] wkprod;
  logic signed [PW:0] gsum, grnd, nsum, nrnd;
  logic signed [31:0] g_re_q, g_im_q, n_re_q, g_val, n_val;
  logic [16:0]        keep;
  logic               accept, load_out;
  cma_pkg::out_t      res_q, out_q;
  logic               out_valid_q;
  cma_pkg::clip_req_t clip_req_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign clip_req_o  = clip_req_q;
  assign load_out    = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
  assign keep        = 17'd65536 - {1'b0, cfg_i.leak_factor};

  always_comb begin
    head_nxt = (head_q == LAST) ? '0 : head_q + 1'b1;
    if (head_q >= k_q) begin
      daddr = head_q - k_q;
    end else begin
      daddr = AW'({1'b0, head_q} + DEPTH - {1'b0, k_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dmem[head_nxt] <= in_data_i;
    end
    drd_q <= dmem[daddr];
    if (state_q == S_WC && clip_rsp_i.done) begin
      wmem[k_q] <= {clip_rsp_i.a[23:0], clip_rsp_i.b[23:0]};
    end
    wrd_q <= wmem[k_q];
  end

  always_comb begin
    x_re = dval_q ? $signed(drd_q[31:16]) : 16'sd0;
    x_im = dval_q ? $signed(drd_q[15:0]) : 16'sd0;
    if (wval_q) begin
      w_re = $signed(wrd_q[47:24]);
      w_im = $signed(wrd_q[23:0]);
    end else begin
      w_re = (k_q == CENTER) ? cma_pkg::ONE_Q16 : 24'sd0;
      w_im = 24'sd0;
    end

    sr_rnd  = sr_q + $signed(SW'(8192));
    si_rnd  = si_q + $signed(SW'(8192));
    yr_full = YW'(sr_rnd >>> 14);
    yi_full = YW'(si_rnd >>> 14);
    ovf_r   = !((&yr_full[YW-1:23]) || !(|yr_full[YW-1:23]));
    ovf_i   = !((&yi_full[YW-1:23]) || !(|yi_full[YW-1:23]));
    yr_sat  = ovf_r ? (yr_full[YW-1] ? 24'sh800000 : 24'sh7fffff) : yr_full[23:0];
    yi_sat  = ovf_i ? (yi_full[YW-1] ? 24'sh800000 : 24'sh7fffff) : yi_full[23:0];

    ysel    = (state_q == S_E1 || state_q == S_E4) ? yr_q : yi_q;
    ysq     = ysel * ysel;
    mag_rnd = mag_q + 48'd524288;
    yd      = ysel * d_q;
    yd_rnd  = yd + 53'sd2048;

    ear    = er_q[40] ? 41'(-er_q) : er_q;
    eai    = ei_q[40] ? 41'(-ei_q) : ei_q;
    psel_e = (state_q == S_P1) ? ear[23:0] : eai[23:0];
    psq    = 48'(psel_e) * 48'(psel_e);

    esel   = (state_q == S_G1 || state_q == S_G4) ? er_q : ei_q;
    gx     = (state_q == S_G1) ? x_re : ((state_q == S_G3) ? x_re_q : x_im_q);
    gprod  = esel * gx;
    gsum   = (state_q == S_G3) ? (pa_q + pb_q) : (pa_q - pb_q);
    grnd   = gsum + $signed((PW + 1)'(8192));
    g_val  = sat_part(64'(grnd >>> 14));

    wkprod = ((state_q == S_N1) ? w_re_q : w_im_q) * $signed({1'b0, keep});
    sgprod = $signed({1'b0, cfg_i.mu}) * ((state_q == S_N2) ? g_re_q : g_im_q);
    nsum   = (pa_q <<< 8) - pb_q;
    nrnd   = nsum + $signed((PW + 1)'(8388608));
    n_val  = sat_part(64'(nrnd >>> 24));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      k_q         <= '0;
      dvalid_q    <= '0;
      wvalid_q    <= '0;
      dval_q      <= 1'b0;
      wval_q      <= 1'b0;
      x_re_q      <= '0;
      x_im_q      <= '0;
      w_re_q      <= '0;
      w_im_q      <= '0;
      m_rr_q      <= '0;
      m_ii_q      <= '0;
      m_ri_q      <= '0;
      m_ir_q      <= '0;
      sr_q        <= '0;
      si_q        <= '0;
      yr_q        <= '0;
      yi_q        <= '0;
      mag_q       <= '0;
      d_q         <= '0;
      er_q        <= '0;
      ei_q        <= '0;
      pwacc_q     <= '0;
      pwsat_q     <= 1'b0;
      pa_q        <= '0;
      pb_q        <= '0;
      g_re_q      <= '0;
      g_im_q      <= '0;
      n_re_q      <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      clip_req_q  <= '0;
    end else begin
      dval_q           <= dvalid_q[daddr];
      wval_q           <= wvalid_q[k_q];
      clip_req_q.start <= 1'b0;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            head_q             <= head_nxt;
            dvalid_q[head_nxt] <= 1'b1;
            k_q                <= '0;
            sr_q               <= '0;
            si_q               <= '0;
            state_q            <= S_FRD;
          end
        end
        S_FRD: state_q <= S_FMUL;
        S_FMUL: begin
          m_rr_q  <= w_re * x_re;
          m_ii_q  <= w_im * x_im;
          m_ri_q  <= w_re * x_im;
          m_ir_q  <= w_im * x_re;
          state_q <= S_FACC;
        end
        S_FACC: begin
          sr_q <= sr_q + SW'(m_rr_q) - SW'(m_ii_q);
          si_q <= si_q + SW'(m_ri_q) + SW'(m_ir_q);
          if (k_q == LAST) begin
            state_q <= S_Y;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_FRD;
          end
        end
        S_Y: begin
          yr_q <= yr_sat;
          yi_q <= yi_sat;
          if (ovf_r || ovf_i) begin
            res_q    <= '{eq_re: yr_sat, eq_im: yi_sat, err_power: '0, diverged: 1'b1};
            dvalid_q <= '0;
            wvalid_q <= '0;
            state_q  <= S_FIN;
          end else begin
            state_q <= S_E1;
          end
        end
        S_E1: begin
          mag_q   <= ysq;
          state_q <= S_E2;
        end
        S_E2: begin
          mag_q   <= mag_q + ysq;
          state_q <= S_E3;
        end
        S_E3: begin
          d_q     <= $signed({1'b0, mag_rnd[47:20]}) - $signed({13'd0, cfg_i.modulus_sq});
          state_q <= S_E4;
        end
        S_E4: begin
          er_q    <= 41'(yd_rnd >>> 12);
          state_q <= S_E5;
        end
        S_E5: begin
          ei_q    <= 41'(yd_rnd >>> 12);
          state_q <= S_P1;
        end
        S_P1: begin
          pwacc_q <= {1'b0, psq};
          pwsat_q <= (|ear[40:24]) || (|eai[40:24]);
          state_q <= S_P2;
        end
        S_P2: begin
          pwacc_q <= pwacc_q + {1'b0, psq};
          state_q <= S_P3;
        end
        S_P3: begin
          res_q.eq_re     <= yr_q;
          res_q.eq_im     <= yi_q;
          res_q.err_power <= (pwsat_q || pwacc_q[48]) ? '1 : pwacc_q[47:16];
          res_q.diverged  <= 1'b0;
          k_q             <= '0;
          state_q         <= S_URD;
        end
        S_URD: state_q <= S_G1;
        S_G1: begin
          x_re_q  <= x_re;
          x_im_q  <= x_im;
          w_re_q  <= w_re;
          w_im_q  <= w_im;
          pa_q    <= gprod;
          state_q <= S_G2;
        end
        S_G2: begin
          pb_q    <= gprod;
          state_q <= S_G3;
        end
        S_G3: begin
          g_re_q  <= g_val;
          pa_q    <= gprod;
          state_q <= S_G4;
        end
        S_G4: begin
          pb_q    <= gprod;
          state_q <= S_G5;
        end
        S_G5: begin
          clip_req_q <= '{start: 1'b1, a: g_re_q, b: g_val, limit: cfg_i.grad_limit};
          state_q    <= S_GC;
        end
        S_GC: begin
          if (clip_rsp_i.done) begin
            g_re_q  <= clip_rsp_i.a;
            g_im_q  <= clip_rsp_i.b;
            state_q <= S_N1;
          end
        end
        S_N1: begin
          pa_q    <= PW'(wkprod);
          state_q <= S_N2;
        end
        S_N2: begin
          pb_q    <= sgprod;
          state_q <= S_N3;
        end
        S_N3: begin
          n_re_q  <= n_val;
          pa_q    <= PW'(wkprod);
          state_q <= S_N4;
        end
        S_N4: begin
          pb_q    <= sgprod;
          state_q <= S_N5;
        end
        S_N5: begin
          clip_req_q <= '{start: 1'b1, a: n_re_q, b: n_val, limit: cma_pkg::W_CLIP};
          state_q    <= S_WC;
        end
        S_WC: begin
          if (clip_rsp_i.done) begin
            wvalid_q[k_q] <= 1'b1;
            if (k_q == LAST) begin
              state_q <= S_FIN;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_URD;
            end
          end
        end
        S_FIN: begin
          if (load_out) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cma_adaptive_equalizer.sv
// Top level of the constant-modulus adaptive equaliser.
// Each beat on the input carries one complex sample; each beat on the output carries the
// equalised sample, the CMA error power and a divergence flag. An item runs through the
// filter sum over all taps through the delay-line and weight memories, then the error terms,
// then the weight update for each tap, which runs the gradient and weight magnitude clips
// through one shared clip unit, and last the loading of the output register once it is free.
// If the filter sum overflows, the item is flagged as diverged and goes straight to that
// load. Whenever a clip actually limits a value, it adds a square root and two divisions.
// One item is in flight at a time, and the next is taken while the previous result waits in
// the output register. Reset and divergence clear the tap state at once through per-entry
// valid bits, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module cma_adaptive_equalizer #(
  parameter int TAPS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire cma_pkg::in_t               in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output cma_pkg::out_t                   out_data_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [cma_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  cma_pkg::cfg_t      cfg;
  cma_pkg::clip_req_t clip_req;
  cma_pkg::clip_rsp_t clip_rsp;

  cma_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cma_clip u_clip (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (clip_req),
    .rsp_o  (clip_rsp)
  );

  cma_core #(
    .TAPS (TAPS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .clip_req_o  (clip_req),
    .clip_rsp_i  (clip_rsp)
  );

endmodule

`default_nettype wire

FILE: rtl/cma_checker.sv
// Port-level checks for the equaliser and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module cma_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire cma_pkg::out_t out_data_o,
  input wire logic          psel,
  input wire logic          pready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output beat changed while stalled");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel |-> pready)
    else $error("configuration port inserted a wait state");

  a_div_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.diverged |-> out_data_o.err_power == 32'd0)
    else $error("diverged beat carries error power");

  a_div_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.diverged |->
      (out_data_o.eq_re == 24'sh7fffff || out_data_o.eq_re == 24'sh800000 ||
       out_data_o.eq_im == 24'sh7fffff || out_data_o.eq_im == 24'sh800000))
    else $error("diverged beat without a saturated output part");

endmodule

bind cma_adaptive_equalizer cma_checker u_checker (.*);

`default_nettype wire

FILE: dv/tb_cma_adaptive_equalizer.sv
// Self-checking testbench for the constant-modulus adaptive equaliser.
`timescale 1ns / 1ps

module tb_cma_adaptive_equalizer;

  localparam int NTAPS = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  cma_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  cma_pkg::out_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [cma_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  cma_adaptive_equalizer #(.TAPS(NTAPS)) u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  cma_pkg::in_t sample_q[$];
  cma_pkg::out_t eq_expected_q[$];
  int n_issued = 0;
  int n_checked = 0;
  int n_errors = 0;
  int idle_in_pct = 0;
  int idle_out_pct = 0;
  logic in_taken = 1'b0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int hold_cnt = 0;

  logic [15:0] cur_modulus_sq;
  logic [23:0] cur_mu;
  logic [15:0] cur_leak_factor;
  logic [31:0] cur_grad_limit;
  longint line_re[NTAPS], line_im[NTAPS];
  longint wt_re[NTAPS], wt_im[NTAPS];

  function automatic longint rnd_shr(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void limit_mag(inout longint a, inout longint b, input longint unsigned lim);
    longint unsigned ua, ub, m2, m;
    ua = a < 0 ? longint'(-a) : longint'(a);
    ub = b < 0 ? longint'(-b) : longint'(b);
    m2 = ua * ua + ub * ub;
    if (m2 <= lim * lim) return;
    m = int_sqrt(m2);
    ua = ua * lim / m;
    ub = ub * lim / m;
    a = a < 0 ? -longint'(ua) : longint'(ua);
    b = b < 0 ? -longint'(ub) : longint'(ub);
  endfunction

  function automatic void unit_weights();
    for (int k = 0; k < NTAPS; k++) begin
      wt_re[k] = 0;
      wt_im[k] = 0;
    end
    wt_re[NTAPS / 2] = 65536;
  endfunction

  function automatic void clear_line();
    for (int k = 0; k < NTAPS; k++) begin
      line_re[k] = 0;
      line_im[k] = 0;
    end
  endfunction

  function automatic cma_pkg::out_t equalise(cma_pkg::in_t s);
    cma_pkg::out_t r;
    longint sr, si, yr, yi, mag, d, er, ei, gr, gi, nr, ni, keep;
    longint unsigned ear, eai, pw;
    sr = 0;
    si = 0;
    keep = 65536 - longint'(cur_leak_factor);
    for (int k = NTAPS - 1; k > 0; k--) begin
      line_re[k] = line_re[k - 1];
      line_im[k] = line_im[k - 1];
    end
    line_re[0] = longint'(s.sample_re);
    line_im[0] = longint'(s.sample_im);
    for (int k = 0; k < NTAPS; k++) begin
      sr += wt_re[k] * line_re[k] - wt_im[k] * line_im[k];
      si += wt_re[k] * line_im[k] + wt_im[k] * line_re[k];
    end
    yr = rnd_shr(sr, 14);
    yi = rnd_shr(si, 14);
    r = '0;
    if (yr < -8388608 || yr > 8388607 || yi < -8388608 || yi > 8388607) begin
      r.eq_re = 24'(clamp(yr, -8388608, 8388607));
      r.eq_im = 24'(clamp(yi, -8388608, 8388607));
      r.diverged = 1'b1;
      unit_weights();
      clear_line();
      return r;
    end
    mag = (yr * yr + yi * yi + (64'sd1 <<< 19)) >>> 20;
    d = mag - longint'(cur_modulus_sq);
    er = rnd_shr(yr * d, 12);
    ei = rnd_shr(yi * d, 12);
    ear = er < 0 ? longint'(-er) : longint'(er);
    eai = ei < 0 ? longint'(-ei) : longint'(ei);
    if (ear >= 64'd16777216 || eai >= 64'd16777216) begin
      pw = 64'hFFFF_FFFF;
    end else begin
      pw = (ear * ear + eai * eai) >> 16;
      if (pw > 64'hFFFF_FFFF) pw = 64'hFFFF_FFFF;
    end
    for (int k = 0; k < NTAPS; k++) begin
      gr = clamp(rnd_shr(er * line_re[k] + ei * line_im[k], 14), -2147483647, 2147483647);
      gi = clamp(rnd_shr(ei * line_re[k] - er * line_im[k], 14), -2147483647, 2147483647);
      limit_mag(gr, gi, longint'(cur_grad_limit));
      nr = wt_re[k] * keep * 256 - longint'(cur_mu) * gr;
      ni = wt_im[k] * keep * 256 - longint'(cur_mu) * gi;
      nr = clamp(rnd_shr(nr, 24), -2147483647, 2147483647);
      ni = clamp(rnd_shr(ni, 24), -2147483647, 2147483647);
      limit_mag(nr, ni, longint'(cma_pkg::W_CLIP));
      wt_re[k] = nr;
      wt_im[k] = ni;
    end
    r.eq_re = 24'(yr);
    r.eq_im = 24'(yi);
    r.err_power = 32'(pw);
    return r;
  endfunction

  always @(posedge clk_i) begin
    cma_pkg::out_t got, want;
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) eq_expected_q = {eq_expected_q, equalise(in_data_i)};
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = out_data_o;
      if (eq_expected_q.size() == 0) begin
        $error("unexpected output beat %h", got);
        n_errors++;
      end else begin
        want = eq_expected_q.pop_front();
        if (got.eq_re !== want.eq_re) begin
          $error("eq_re expected %0d got %0d", want.eq_re, got.eq_re);
          n_errors++;
        end
        if (got.eq_im !== want.eq_im) begin
          $error("eq_im expected %0d got %0d", want.eq_im, got.eq_im);
          n_errors++;
        end
        if (got.err_power !== want.err_power) begin
          $error("err_power expected %0d got %0d", want.err_power, got.err_power);
          n_errors++;
        end
        if (got.diverged !== want.diverged) begin
          $error("diverged expected %0d got %0d", want.diverged, got.diverged);
          n_errors++;
        end
        n_checked++;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (rst_ni && sample_q.size() > 0 && $urandom_range(99) >= idle_in_pct) begin
        in_data_i <= sample_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_go && !hold_done) begin
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt >= 3000) hold_done <= 1'b1;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= (hold_go && !hold_done) ? 1'b0 : ($urandom_range(99) >= idle_out_pct);
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      cma_pkg::REG_MODULUS_SQ:  cur_modulus_sq = val[15:0];
      cma_pkg::REG_MU:          cur_mu = val[23:0];
      cma_pkg::REG_LEAK_FACTOR: cur_leak_factor = val[15:0];
      cma_pkg::REG_GRAD_LIMIT:  cur_grad_limit = val;
      default: ;
    endcase
  endtask

  task automatic load_regs(logic [15:0] ms, logic [23:0] st, logic [15:0] lk, logic [31:0] gl);
    reg_write(cma_pkg::REG_MODULUS_SQ, {16'($urandom_range(65535)), ms});
    reg_write(cma_pkg::REG_MU, {8'($urandom_range(255)), st});
    reg_write(cma_pkg::REG_LEAK_FACTOR, {16'($urandom_range(65535)), lk});
    reg_write(cma_pkg::REG_GRAD_LIMIT, gl);
  endtask

  task automatic push_sample(logic [15:0] re, logic [15:0] im);
    cma_pkg::in_t s;
    s.sample_re = re;
    s.sample_im = im;
    sample_q = {sample_q, s};
    n_issued++;
  endtask

  task automatic push_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 70)
        push_sample(16'($urandom_range(8192) - 4096), 16'($urandom_range(8192) - 4096));
      else
        push_sample(16'($urandom), 16'($urandom));
    end
  endtask

  task automatic drain();
    do @(negedge clk_i); while (n_checked != n_issued);
  endtask

  initial begin
    cur_modulus_sq = cma_pkg::RST_MODULUS_SQ;
    cur_mu = cma_pkg::RST_MU;
    cur_leak_factor = cma_pkg::RST_LEAK_FACTOR;
    cur_grad_limit = cma_pkg::RST_GRAD_LIMIT;
    clear_line();
    unit_weights();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    push_sample(16'h0000, 16'h0000);
    push_sample(16'h7FFF, 16'h7FFF);
    push_sample(16'h8000, 16'h8000);
    push_sample(16'h7FFF, 16'h8000);
    push_sample(16'h8000, 16'h7FFF);
    push_sample(16'h5555, 16'hAAAA);
    push_sample(16'hAAAA, 16'h5555);
    push_sample(16'h1000, 16'h0000);
    push_sample(16'h0000, 16'hF000);
    push_sample(16'hFFFF, 16'h0001);
    push_random(10);
    drain();

    load_regs(16'hFFFF, 24'hFFFFFF, 16'h0000, 32'hFFFF_FFFF);
    push_random(150);
    drain();

    idle_in_pct = 63;
    load_regs(16'h0000, 24'h000001, 16'hFFFF, 32'h0000_0000);
    push_random(150);
    drain();

    idle_in_pct = 0;
    idle_out_pct = 63;
    load_regs(16'($urandom), 24'($urandom), 16'($urandom_range(4096)), $urandom);
    push_random(200);
    hold_go = 1'b1;
    drain();

    idle_in_pct = 20;
    idle_out_pct = 20;
    load_regs(16'd4096, 24'd0, 16'd1000, 32'd65536);
    push_random(200);
    drain();

    idle_in_pct = 0;
    idle_out_pct = 0;
    load_regs(16'd4096, 24'd2000000, 16'd16, 32'd300000);
    push_random(300);
    drain();

    repeat (100) @(posedge clk_i);
    if (n_errors == 0 && eq_expected_q.size() == 0) begin
      $display("tb_cma_adaptive_equalizer: clean");
    end else begin
      $display("tb_cma_adaptive_equalizer: errors");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("tb_cma_adaptive_equalizer: errors");
    $finish;
  end

endmodule
